[rtl/core/assert_macros.svh]
// Assertion macros shared by the voice RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ESV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ESV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/esv_pkg.sv]
// Shared types, register codes and sine table arithmetic for the voice.
package esv_pkg;

    typedef enum logic [1:0] {
        REG_PHASE_STEP   = 2'd0,
        REG_NOTE_START   = 2'd1,
        REG_NOTE_LENGTH  = 2'd2,
        REG_VOICE_ENABLE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [47:0] note_start;
        logic [30:0] note_length;
        logic        voice_enable;
    } cfg_t;

    // One classified item between front and back.
    typedef struct packed {
        logic        sounding;
        logic [14:0] gain;
    } qitem_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // Taylor divisor (2n)(2n+1) for term n.
    function automatic logic [63:0] taylor_div(input int unsigned n, input logic [63:0] x);
        unique case (n)
            1:       return x / 64'd6;
            2:       return x / 64'd20;
            3:       return x / 64'd42;
            4:       return x / 64'd72;
            5:       return x / 64'd110;
            6:       return x / 64'd156;
            7:       return x / 64'd210;
            8:       return x / 64'd272;
            9:       return x / 64'd342;
            default: return x / 64'd420;
        endcase
    endfunction

    // round(32767 * sin(pi/2 * j / quarter)), quarter = 2^(index_bits-2); Q30 series.
    function automatic logic [15:0] quarter_sine(input logic [15:0] j,
                                                 input int unsigned index_bits);
        logic [63:0]        theta;
        logic [63:0]        theta2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        theta  = (PI_Q30 * 64'(j)) >> (index_bits - 1);
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = signed'(theta);
        for (int unsigned n = 1; n <= 10; n++)
        begin
            term = taylor_div(n, (term * theta2) >> 30);
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > signed'(ONE_Q30))
            sum = signed'(ONE_Q30);
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767)
            v = 64'sd32767;
        return v[15:0];
    endfunction

endpackage

[rtl/core/esv_cfg.sv]
// Configuration register file for the voice.
module esv_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [47:0]      cfg_data,
    output esv_pkg::cfg_t    cfg
);
    import esv_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PHASE_STEP:   cfg_reg.phase_step   <= cfg_data[31:0];
                REG_NOTE_START:   cfg_reg.note_start   <= cfg_data;
                REG_NOTE_LENGTH:  cfg_reg.note_length  <= cfg_data[30:0];
                REG_VOICE_ENABLE: cfg_reg.voice_enable <= cfg_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/esv_front.sv]
// Front end: accepts time items, decides activity and fade gain.
module esv_front #(
    parameter int FADE_MS = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  esv_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [47:0]      time_now,
    output logic             push,
    output esv_pkg::qitem_t  push_item,
    input  logic             q_full
);
    import esv_pkg::*;

    localparam int KW = (FADE_MS < 2) ? 1 : $clog2(FADE_MS + 1);

    typedef logic [14:0] gain_lut_t [FADE_MS + 1];

    function automatic gain_lut_t build_gain();
        gain_lut_t r;
        for (int k = 0; k <= FADE_MS; k++)
        begin
            r[k] = 15'((k * 32767) / FADE_MS);
        end
        return r;
    endfunction

    localparam gain_lut_t GAIN_LUT = build_gain();

    // stage A: start compare and elapsed time
    logic        a_valid_reg;
    logic        a_ge_reg;
    logic [47:0] a_elapsed_reg;
    // stage B: classified item waiting for the queue
    logic        b_valid_reg;
    qitem_t      b_item_reg;

    logic        a_adv;
    logic        b_adv;
    logic        active;
    logic [30:0] rem;
    logic [KW-1:0] k;
    qitem_t      b_item_next;

    assign b_adv    = !b_valid_reg || !q_full;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    assign active = cfg.voice_enable && a_ge_reg && (a_elapsed_reg < {17'b0, cfg.note_length});
    assign rem    = cfg.note_length - a_elapsed_reg[30:0];

    // fade-in first, then fade-out
    always_comb
    begin
        priority if (a_elapsed_reg < 48'(FADE_MS))
            k = a_elapsed_reg[KW-1:0];
        else if (rem < 31'(FADE_MS))
            k = rem[KW-1:0];
        else
            k = KW'(FADE_MS);
    end

    always_comb
    begin
        b_item_next.sounding = active;
        b_item_next.gain     = active ? GAIN_LUT[k] : 15'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= in_valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_adv)
        begin
            a_ge_reg      <= (time_now >= cfg.note_start);
            a_elapsed_reg <= time_now - cfg.note_start;
        end
        if (a_valid_reg && b_adv)
            b_item_reg <= b_item_next;
    end

    assign push      = b_valid_reg && !q_full;
    assign push_item = b_item_reg;

endmodule

[rtl/core/esv_queue.sv]
// Small FIFO of classified items between front and back.
module esv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  esv_pkg::qitem_t  push_item,
    input  logic             pop,
    output esv_pkg::qitem_t  pop_item,
    output logic             full,
    output logic             empty
);
    import esv_pkg::*;
    `include "assert_macros.svh"

    qitem_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full     = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    `ESV_ASSERT_NOW(a_q_bound, 1'b1, count_reg <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH), "queue overfilled")
    `ESV_ASSERT_NOW(a_q_pop, pop, !empty, "pop from empty queue")
    `ESV_ASSERT_NEXT(a_q_grow, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

[rtl/core/esv_back.sv]
// Back end: phase accumulator, sine ROM, gain multiply, output register.
module esv_back #(
    parameter int SINE_INDEX_BITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  esv_pkg::cfg_t    cfg,
    input  esv_pkg::qitem_t  pop_item,
    input  logic             q_empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      sample_out,
    output logic             sounding
);
    import esv_pkg::*;
    `include "assert_macros.svh"

    localparam int TABLE_SIZE = 1 << SINE_INDEX_BITS;
    localparam int QUARTER    = TABLE_SIZE / 4;

    typedef logic [15:0] rom_t [TABLE_SIZE];

    // full-wave table from quarter-wave symmetry
    function automatic rom_t build_rom();
        rom_t        r;
        int unsigned q;
        int unsigned j;
        logic [15:0] s;
        for (int unsigned i = 0; i < TABLE_SIZE; i++)
        begin
            q = i >> (SINE_INDEX_BITS - 2);
            j = i & (QUARTER - 1);
            if (q[0])
                s = quarter_sine(16'(QUARTER - j), SINE_INDEX_BITS);
            else
                s = quarter_sine(16'(j), SINE_INDEX_BITS);
            r[i] = q[1] ? 16'(-s) : s;
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [31:0]              phase_acc_reg;
    logic [31:0]              phase_next;
    logic [SINE_INDEX_BITS-1:0] rom_idx;
    logic                     adv;

    logic                     s1_valid_reg;
    logic                     s1_sounding_reg;
    logic [14:0]              s1_gain_reg;
    logic [15:0]              s1_sine_reg;

    logic                     s2_valid_reg;
    logic                     s2_sounding_reg;
    logic signed [31:0]       s2_prod_reg;

    logic                     out_valid_reg;
    logic                     sounding_reg;
    logic [15:0]              sample_reg;

    // whole back pipeline moves together; output register parts it from the sink
    assign adv        = !out_valid_reg || out_ready;
    assign pop        = adv && !q_empty;
    assign phase_next = phase_acc_reg + cfg.phase_step;
    assign rom_idx    = phase_next[31 -: SINE_INDEX_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && pop_item.sounding)
                phase_acc_reg <= phase_next;
            if (adv)
            begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sine_reg     <= SINE_ROM[rom_idx];
            s1_sounding_reg <= pop_item.sounding;
            s1_gain_reg     <= pop_item.sounding ? pop_item.gain : 15'd0;
            s2_sounding_reg <= s1_sounding_reg;
            s2_prod_reg     <= signed'(s1_sine_reg) * signed'({1'b0, s1_gain_reg});
            sounding_reg    <= s2_sounding_reg;
            // arithmetic shift by 15; product magnitude stays below 2^30
            sample_reg      <= s2_prod_reg[30:15];
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;
    assign sounding   = sounding_reg;

    `ESV_ASSERT_NEXT(a_phase_hold, !(pop && pop_item.sounding), $stable(phase_acc_reg),
        "phase moved on a silent item")
    `ESV_ASSERT_NOW(a_silent_gain, s1_valid_reg && !s1_sounding_reg, s1_gain_reg == 15'd0,
        "silent item carries gain")
    `ESV_ASSERT_NOW(a_silent_out, out_valid_reg && !sounding_reg, sample_reg == 16'd0,
        "silent item with nonzero sample")

endmodule

[rtl/core/enveloped_sine_voice.sv]
// Top level of the enveloped sine voice: config, front end, queue, back end.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    time_now[47:0]
//   out       output     out_valid/out_ready  sample_out[15:0], sounding
//   cfg       input      cfg_write            cfg_index[1:0], cfg_data[47:0]
//
// One item per cycle sustained while out_ready stays high; the phase accumulator is a single 32-bit add.
// The path runs through two front stages, the queue, ROM read, multiply and output.
// rst_n clears all control state and the phase accumulator; no clearing pass.
// Front and back stall independently; the four-entry queue absorbs the difference.
module enveloped_sine_voice #(
    parameter int SINE_INDEX_BITS = 10,
    parameter int FADE_MS         = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] time_now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sample_out,
    output logic        sounding
);
    import esv_pkg::*;

    cfg_t   cfg;
    logic   push;
    qitem_t push_item;
    logic   pop;
    qitem_t pop_item;
    logic   q_full;
    logic   q_empty;

    esv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    esv_front #(
        .FADE_MS (FADE_MS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .time_now  (time_now),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    esv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    esv_back #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pop_item   (pop_item),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .sounding   (sounding)
    );

endmodule
